// ===== rtl/sssp_pkg.sv =====
// ----------------------------------------------------------------------------
// sssp_pkg: shared types, constants and tables for the sine soft-start ramp
// Drive codes, duty update modes, the control word passed down the pipe and
// the quarter-sine lookup contents.
// ----------------------------------------------------------------------------
package sssp_pkg;

  localparam int RAMP_STEPS = 100;
  localparam int ROM_AW     = $clog2(RAMP_STEPS + 1);
  localparam int CNT_W      = 8;
  localparam int SINE_W     = 17;
  localparam int DUTY_W     = 16;
  localparam int STEP_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam logic [1:0] DRV_STOP = 2'd0;
  localparam logic [1:0] DRV_UP   = 2'd1;
  localparam logic [1:0] DRV_DOWN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_START_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DUTY  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY   = 2'd3;

  typedef enum logic [1:0] {
    DUTY_HOLD,
    DUTY_RAMP,
    DUTY_ZERO
  } duty_mode_t;

  // Control word for one beat, from the update stage to the duty stage
  typedef struct packed {
    logic              up_pin;
    logic              down_pin;
    logic              enable;
    logic              full;
    duty_mode_t        mode;
    logic [DUTY_W-1:0] mul;
    logic [DUTY_W-1:0] add;
  } ctl_t;

  typedef logic [SINE_W-1:0] sine_tab_t [RAMP_STEPS+1];

  // Quarter-sine in unsigned Q16 over the ramp, Taylor series to x^15
  function automatic sine_tab_t build_sine();
    sine_tab_t       tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned r;
    for (int i = 0; i <= RAMP_STEPS; i++) begin
      x    = longint'(i) * HALF_PI_Q30 / RAMP_STEPS;
      x2   = (x * x) >> 30;
      pos  = x;
      term = ((x * x2) >> 30) / 6;
      neg  = term;
      term = ((term * x2) >> 30) / 20;
      pos  = pos + term;
      term = ((term * x2) >> 30) / 42;
      neg  = neg + term;
      term = ((term * x2) >> 30) / 72;
      pos  = pos + term;
      term = ((term * x2) >> 30) / 110;
      neg  = neg + term;
      term = ((term * x2) >> 30) / 156;
      pos  = pos + term;
      term = ((term * x2) >> 30) / 210;
      neg  = neg + term;
      if (neg >= pos) begin
        r = 0;
      end else begin
        r = (pos - neg + 8192) >> 14;
      end
      if (r > 65536) begin
        r = 65536;
      end
      tab[i] = r[SINE_W-1:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

// ===== rtl/sine_soft_start_pwm_ramp.sv =====
// ----------------------------------------------------------------------------
// sine_soft_start_pwm_ramp: sine-profile soft start / soft stop for a motor
// Ramp tick in, pin levels and PWM duty out.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one tick: drive command (stop, up, down) and the limit and
//   obstacle trips. m_* returns one beat per tick: both direction pins, PWM
//   enable, full-on flag and the duty compare value for the timer.
//   cfg_* writes start_step, stop_step, base_duty and max_duty; write only
//   while no tick is in flight.
// Pipeline and throughput:
//   A tick's result passes the control-word and sine registers, then the
//   output register, before it shows on m_tvalid. One tick per cycle is taken
//   while the output side keeps up: the counter and pin update and the sine
//   lookup read are registered at the accept edge, and the duty multiply-add that follows feeds the output register.
// Reset:
//   Counter, direction and pins clear, duty reads zero, steps return to 1,
//   base duty to 0 and max duty to 1000.
// Stall:
//   While a result waits with m_tready low, s_tready drops and the whole
//   pipe holds; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module sine_soft_start_pwm_ramp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // drive_cmd[1:0], up_limit, obstacle
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [23:0]                      m_tdata,   // dir_up_pin, dir_down_pin,
                                                      // pwm_enable, pwm_full, duty_value[15:0]
  input  logic                             cfg_we,
  input  logic [sssp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sssp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sssp_pkg::*;

  logic               advance;
  logic               accept;
  logic [ROM_AW-1:0]  rom_addr;
  logic [SINE_W-1:0]  sine;
  logic               stg_valid;
  ctl_t               stg;
  logic [DUTY_W+SINE_W-1:0] prod;
  logic [DUTY_W-1:0]  duty_next;

  logic               dir_up_pin;
  logic               dir_down_pin;
  logic               pwm_enable;
  logic               pwm_full;
  logic [DUTY_W-1:0]  duty_value;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;
  assign accept   = s_tvalid && advance;

  sssp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .accept    (accept),
    .drive_cmd (s_tdata[1:0]),
    .trip      (s_tdata[2] || s_tdata[3]),
    .rom_addr  (rom_addr),
    .stg_valid (stg_valid),
    .stg       (stg)
  );

  sssp_sine_rom u_rom (
    .clk  (clk),
    .en   (advance),
    .addr (rom_addr),
    .data (sine)
  );

  assign prod = (DUTY_W+SINE_W)'(stg.mul) * (DUTY_W+SINE_W)'(sine);

  always_comb begin
    unique case (stg.mode)
      DUTY_RAMP: duty_next = stg.add + prod[DUTY_W+15:16];
      DUTY_ZERO: duty_next = '0;
      default:   duty_next = duty_value;
    endcase
  end

  // Output register doubles as the held pin and duty state
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid     <= 1'b0;
      dir_up_pin   <= 1'b0;
      dir_down_pin <= 1'b0;
      pwm_enable   <= 1'b0;
      pwm_full     <= 1'b0;
      duty_value   <= '0;
    end else if (advance) begin
      m_tvalid <= stg_valid;
      if (stg_valid) begin
        dir_up_pin   <= stg.up_pin;
        dir_down_pin <= stg.down_pin;
        pwm_enable   <= stg.enable;
        pwm_full     <= stg.full;
        duty_value   <= duty_next;
      end
    end
  end

  assign m_tdata = {4'b0, duty_value, pwm_full, pwm_enable, dir_down_pin, dir_up_pin};

  a_pins_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(dir_up_pin && dir_down_pin))
    else $error("both direction pins driven");

  a_full_needs_enable: assert property (@(posedge clk) disable iff (rst)
    pwm_full |-> pwm_enable)
    else $error("full-on without PWM enable");

  a_off_duty_zero: assert property (@(posedge clk) disable iff (rst)
    !pwm_enable |-> (duty_value == '0))
    else $error("duty nonzero while PWM is off");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (stg_valid && !advance) |=> (stg_valid && $stable(stg)))
    else $error("pending beat lost during output stall");

endmodule

// ===== rtl/sssp_sine_rom.sv =====
// ----------------------------------------------------------------------------
// sssp_sine_rom: quarter-sine lookup memory
// Synchronous read with a registered output; data holds while enable is low.
// ----------------------------------------------------------------------------
module sssp_sine_rom (
  input  logic                         clk,
  input  logic                         en,
  input  logic [sssp_pkg::ROM_AW-1:0]  addr,
  output logic [sssp_pkg::SINE_W-1:0]  data
);
  import sssp_pkg::*;

  logic [SINE_W-1:0] mem [RAMP_STEPS+1];

  assign mem = SINE_TAB;

  always_ff @(posedge clk) begin
    if (en) begin
      data <= mem[addr];
    end
  end

endmodule

// ===== rtl/sssp_ctrl.sv =====
// ----------------------------------------------------------------------------
// sssp_ctrl: ramp state and configuration
// Holds the counter, direction and pin state, updates them on each accepted
// beat, and registers the control word for the duty stage.
// ----------------------------------------------------------------------------
module sssp_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sssp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sssp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             advance,
  input  logic                             accept,
  input  logic [1:0]                       drive_cmd,
  input  logic                             trip,
  output logic [sssp_pkg::ROM_AW-1:0]      rom_addr,
  output logic                             stg_valid,
  output sssp_pkg::ctl_t                   stg
);
  import sssp_pkg::*;

  localparam logic [CNT_W-1:0] RAMP_END = CNT_W'(RAMP_STEPS);

  logic [STEP_W-1:0] start_step;
  logic [STEP_W-1:0] stop_step;
  logic [DUTY_W-1:0] base_duty;
  logic [DUTY_W-1:0] max_duty;

  logic [CNT_W-1:0] ramp_count;
  logic [CNT_W-1:0] ramp_count_next;
  logic [1:0]       last_drive;
  logic [1:0]       last_drive_next;
  logic             up_pin;
  logic             up_pin_next;
  logic             down_pin;
  logic             down_pin_next;
  logic             enable;
  logic             enable_next;
  logic             full;
  logic             full_next;
  duty_mode_t       mode_next;
  logic [DUTY_W-1:0] mul_next;
  logic [DUTY_W-1:0] add_next;

  logic [DUTY_W-1:0] span;
  logic [CNT_W-1:0]  cnt_start;
  logic [CNT_W:0]    cnt_sum;
  logic [CNT_W-1:0]  stop_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_step <= STEP_W'(1);
      stop_step  <= STEP_W'(1);
      base_duty  <= '0;
      max_duty   <= DUTY_W'(1000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_STEP: start_step <= cfg_data[STEP_W-1:0];
        REG_STOP_STEP:  stop_step  <= cfg_data[STEP_W-1:0];
        REG_BASE_DUTY:  base_duty  <= cfg_data[DUTY_W-1:0];
        REG_MAX_DUTY:   max_duty   <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Sine index uses the counter as it stands before this beat's update
  assign rom_addr = (ramp_count > RAMP_END) ? ROM_AW'(RAMP_STEPS) : ramp_count[ROM_AW-1:0];

  assign span     = (max_duty > base_duty) ? (max_duty - base_duty) : '0;
  assign stop_ext = CNT_W'(stop_step);

  always_comb begin
    ramp_count_next = ramp_count;
    last_drive_next = last_drive;
    up_pin_next     = up_pin;
    down_pin_next   = down_pin;
    enable_next     = enable;
    full_next       = full;
    mode_next       = DUTY_HOLD;
    mul_next        = '0;
    add_next        = '0;
    cnt_start       = ramp_count;
    cnt_sum         = '0;
    case (drive_cmd)
      DRV_UP, DRV_DOWN: begin
        up_pin_next     = (drive_cmd == DRV_UP);
        down_pin_next   = (drive_cmd == DRV_DOWN);
        last_drive_next = drive_cmd;
        // restart the ramp on a new direction
        cnt_start       = (last_drive != drive_cmd) ? '0 : ramp_count;
        ramp_count_next = cnt_start;
        if (cnt_start < RAMP_END) begin
          cnt_sum = {1'b0, cnt_start} + (CNT_W+1)'(start_step);
          ramp_count_next = cnt_sum[CNT_W] ? {CNT_W{1'b1}} : cnt_sum[CNT_W-1:0];
        end
        enable_next = 1'b1;
        if (ramp_count_next >= RAMP_END) begin
          full_next = 1'b1;
        end else begin
          full_next = 1'b0;
          mode_next = DUTY_RAMP;
          mul_next  = span;
          add_next  = base_duty;
        end
      end
      DRV_STOP: begin
        if (trip) begin
          up_pin_next   = 1'b0;
          down_pin_next = 1'b0;
          enable_next   = 1'b0;
          full_next     = 1'b0;
        end
        last_drive_next = DRV_STOP;
        if (ramp_count > stop_ext) begin
          ramp_count_next = ramp_count - stop_ext;
        end
        if (ramp_count_next <= stop_ext) begin
          up_pin_next     = 1'b0;
          down_pin_next   = 1'b0;
          enable_next     = 1'b0;
          full_next       = 1'b0;
          ramp_count_next = '0;
          mode_next       = DUTY_ZERO;
        end else begin
          enable_next = 1'b1;
          full_next   = 1'b0;
          mode_next   = DUTY_RAMP;
          mul_next    = max_duty;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_count <= '0;
      last_drive <= DRV_STOP;
      up_pin     <= 1'b0;
      down_pin   <= 1'b0;
      enable     <= 1'b0;
      full       <= 1'b0;
    end else if (accept) begin
      ramp_count <= ramp_count_next;
      last_drive <= last_drive_next;
      up_pin     <= up_pin_next;
      down_pin   <= down_pin_next;
      enable     <= enable_next;
      full       <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (advance) begin
      stg_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stg.up_pin   <= up_pin_next;
      stg.down_pin <= down_pin_next;
      stg.enable   <= enable_next;
      stg.full     <= full_next;
      stg.mode     <= mode_next;
      stg.mul      <= mul_next;
      stg.add      <= add_next;
    end
  end

endmodule

// ===== tb/ramp_checker.sv =====
// ----------------------------------------------------------------------------
// ramp_checker: result checker for the sine soft-start ramp
// Watches the tick, result and register write channels, tracks its own copy
// of the ramp counter, pins and duty, and compares every result beat field by
// field against the oldest predicted beat.
// ----------------------------------------------------------------------------
module ramp_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // drive_cmd[1:0], up_limit, obstacle
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [23:0]                     m_tdata,   // dir_up_pin, dir_down_pin,
                                                     // pwm_enable, pwm_full, duty_value[15:0]
  input  logic                            cfg_we,
  input  logic [sssp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sssp_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              checked,
  output int                              full_seen
);
  import sssp_pkg::*;

  typedef struct packed {
    logic              up_pin;
    logic              down_pin;
    logic              enable;
    logic              full;
    logic [DUTY_W-1:0] duty;
  } drive_beat_t;

  logic [STEP_W-1:0] inc_step;
  logic [STEP_W-1:0] dec_step;
  logic [DUTY_W-1:0] base_q;
  logic [DUTY_W-1:0] top_duty;

  logic [CNT_W-1:0]  ramp_cnt;
  logic [1:0]        prev_dir;
  logic              up_q;
  logic              dn_q;
  logic              en_q;
  logic              full_q;
  logic [DUTY_W-1:0] duty_q;

  drive_beat_t       beat_q[$];
  drive_beat_t       want;
  drive_beat_t       got;

  // Quarter sine of the counter in unsigned Q16, series summed in Q30
  function automatic logic [SINE_W-1:0] quarter_sine(input logic [CNT_W-1:0] cnt);
    longint unsigned ang;
    longint unsigned ang2;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned rnd;
    longint unsigned div;
    if (cnt > CNT_W'(RAMP_STEPS)) begin
      ang = 64'(RAMP_STEPS);
    end else begin
      ang = 64'(cnt);
    end
    ang  = ang * HALF_PI_Q30 / 64'(RAMP_STEPS);
    ang2 = (ang * ang) >> 30;
    term = ang;
    pos  = ang;
    neg  = 64'd0;
    for (int k = 1; k <= 7; k++) begin
      div  = 64'(2 * k * (2 * k + 1));
      term = ((term * ang2) >> 30) / div;
      if (k % 2 == 1) begin
        neg += term;
      end else begin
        pos += term;
      end
    end
    if (neg >= pos) begin
      return '0;
    end
    rnd = (pos - neg + 64'd8192) >> 14;
    if (rnd > 64'd65536) begin
      rnd = 64'd65536;
    end
    return rnd[SINE_W-1:0];
  endfunction

  task automatic advance_motor(input logic [1:0] cmd, input logic trip,
                               output drive_beat_t res);
    logic [SINE_W-1:0] s;
    longint unsigned   span;
    longint unsigned   acc;
    int unsigned       nxt;
    // sine is taken from the counter as it stood before this tick
    s = quarter_sine(ramp_cnt);
    if (cmd == DRV_UP || cmd == DRV_DOWN) begin
      span = (top_duty > base_q) ? 64'(top_duty - base_q) : 64'd0;
      up_q = (cmd == DRV_UP);
      dn_q = (cmd == DRV_DOWN);
      if (prev_dir != cmd) begin
        ramp_cnt = '0;
        prev_dir = cmd;
      end
      if (ramp_cnt < CNT_W'(RAMP_STEPS)) begin
        nxt = 32'(ramp_cnt) + 32'(inc_step);
        ramp_cnt = (nxt > 32'd255) ? 8'd255 : nxt[CNT_W-1:0];
      end
      en_q = 1'b1;
      if (ramp_cnt >= CNT_W'(RAMP_STEPS)) begin
        // hold the last duty while full-on is forced
        full_q = 1'b1;
      end else begin
        full_q = 1'b0;
        acc    = 64'(base_q) + ((span * 64'(s)) >> 16);
        duty_q = acc[DUTY_W-1:0];
      end
    end else if (cmd == DRV_STOP) begin
      if (trip) begin
        up_q   = 1'b0;
        dn_q   = 1'b0;
        en_q   = 1'b0;
        full_q = 1'b0;
      end
      prev_dir = DRV_STOP;
      if (ramp_cnt > CNT_W'(dec_step)) begin
        ramp_cnt = ramp_cnt - CNT_W'(dec_step);
      end
      if (ramp_cnt <= CNT_W'(dec_step)) begin
        up_q     = 1'b0;
        dn_q     = 1'b0;
        en_q     = 1'b0;
        full_q   = 1'b0;
        duty_q   = '0;
        ramp_cnt = '0;
      end else begin
        en_q   = 1'b1;
        full_q = 1'b0;
        acc    = 64'(top_duty);
        acc    = (acc * 64'(s)) >> 16;
        duty_q = acc[DUTY_W-1:0];
      end
    end
    res = '{up_pin: up_q, down_pin: dn_q, enable: en_q, full: full_q, duty: duty_q};
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      inc_step   = 6'd1;
      dec_step   = 6'd1;
      base_q     = 16'd0;
      top_duty   = 16'd1000;
      ramp_cnt   = '0;
      prev_dir   = DRV_STOP;
      up_q       = 1'b0;
      dn_q       = 1'b0;
      en_q       = 1'b0;
      full_q     = 1'b0;
      duty_q     = '0;
      fail_count = 0;
      checked    = 0;
      full_seen  = 0;
      beat_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.up_pin   = m_tdata[0];
        got.down_pin = m_tdata[1];
        got.enable   = m_tdata[2];
        got.full     = m_tdata[3];
        got.duty     = m_tdata[19:4];
        if (beat_q.size() == 0) begin
          $error("result beat %h with no tick waiting", m_tdata);
          fail_count++;
        end else begin
          want = beat_q.pop_front();
          checked++;
          if (want.full) begin
            full_seen++;
          end
          check_field("dir_up_pin", 32'(want.up_pin), 32'(got.up_pin));
          check_field("dir_down_pin", 32'(want.down_pin), 32'(got.down_pin));
          check_field("pwm_enable", 32'(want.enable), 32'(got.enable));
          check_field("pwm_full", 32'(want.full), 32'(got.full));
          check_field("duty_value", 32'(want.duty), 32'(got.duty));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_START_STEP: inc_step = cfg_data[STEP_W-1:0];
          REG_STOP_STEP:  dec_step = cfg_data[STEP_W-1:0];
          REG_BASE_DUTY:  base_q   = cfg_data[DUTY_W-1:0];
          REG_MAX_DUTY:   top_duty = cfg_data[DUTY_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        advance_motor(s_tdata[1:0], s_tdata[2] | s_tdata[3], want);
        beat_q.push_back(want);
      end
    end
    pending <= beat_q.size();
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench top for the sine soft-start ramp
// Drives ticks through directed cases and random start/stop sessions under a
// series of register settings, with random gaps and output stalls, and one
// long output hold-off that backs up the pipe. The checker predicts each beat.
// ----------------------------------------------------------------------------
module tb;
  import sssp_pkg::*;

  // drive code that the block ignores
  localparam logic [1:0] DRV_HOLD    = 2'd3;
  localparam int         PHASE_TICKS = 170;
  localparam int         STALL_AT    = 400;
  localparam int         STALL_LEN   = 300;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata   = '0;    // drive_cmd[1:0], up_limit, obstacle
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [23:0]           m_tdata;           // dir_up_pin, dir_down_pin,
                                            // pwm_enable, pwm_full, duty_value[15:0]
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int                    fail_count;
  int                    pending;
  int                    checked;
  int                    full_seen;
  int                    ticks_sent    = 0;
  int                    settings_used = 0;
  bit                    gapless       = 1'b0;
  int                    cur_start     = 1;
  int                    cur_stop      = 1;

  always #1 clk = ~clk;

  sine_soft_start_pwm_ramp uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ramp_checker chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .full_seen  (full_seen)
  );

  function automatic int pick_gap();
    int r;
    if (gapless) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  task automatic send_tick(input logic [1:0] cmd, input logic lim, input logic obs);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {4'b0000, obs, lim, cmd};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ticks_sent++;
  endtask

  // Drop valid and wait for every predicted beat to drain, plus pipe slack
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  task automatic apply_setting(input int start, input int stop, input int base,
                               input int top);
    settle();
    write_reg(REG_START_STEP, start);
    write_reg(REG_STOP_STEP, stop);
    write_reg(REG_BASE_DUTY, base);
    write_reg(REG_MAX_DUTY, top);
    cfg_we    <= 1'b0;
    cur_start  = start;
    cur_stop   = stop;
    settings_used++;
  endtask

  // Drive in one direction, maybe reverse, then coast down toward switch-off
  task automatic ramp_session();
    logic [1:0] dir;
    int         up_len;
    int         down_len;
    dir    = $urandom_range(0, 1) ? DRV_UP : DRV_DOWN;
    up_len = $urandom_range(1, (cur_start == 0) ? 40 : RAMP_STEPS / cur_start + 10);
    repeat (up_len) send_tick(dir, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 3) == 0) begin
      dir = (dir == DRV_UP) ? DRV_DOWN : DRV_UP;
      repeat ($urandom_range(1, 20)) begin
        send_tick(dir, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
    down_len = $urandom_range(1, (cur_stop == 0) ? 4 : RAMP_STEPS / cur_stop + 4);
    repeat (down_len) begin
      send_tick(DRV_STOP, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
    end
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 6)) begin
      send_tick(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_phase();
    int target;
    target = ticks_sent + PHASE_TICKS;
    while (ticks_sent < target) begin
      gapless = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0) begin
        ramp_session();
      end else begin
        noise_burst();
      end
    end
    gapless = 1'b0;
  endtask

  initial begin : receiver
    int  burst;
    int  hold;
    int  r;
    bit  long_done;
    long_done = 1'b0;
    @(negedge rst);
    forever begin
      // back the pipe up once so the input side has to stall
      if (!long_done && ticks_sent >= STALL_AT) begin
        long_done = 1'b1;
        m_tready <= 1'b0;
        repeat (STALL_LEN) @(posedge clk);
      end
      burst = $urandom_range(1, 40);
      m_tready <= 1'b1;
      repeat (burst) @(posedge clk);
      r = $urandom_range(0, 99);
      if (r < 50) begin
        hold = 0;
      end else if (r < 85) begin
        hold = $urandom_range(1, 3);
      end else if (r < 96) begin
        hold = $urandom_range(4, 10);
      end else begin
        hold = $urandom_range(20, 60);
      end
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: fast ramp so full-on and switch-off come quickly
    apply_setting(50, 10, 100, 40000);
    send_tick(DRV_HOLD, 1'b0, 1'b0);
    send_tick(DRV_STOP, 1'b1, 1'b1);
    send_tick(DRV_UP, 1'b1, 1'b0);
    send_tick(DRV_UP, 1'b0, 1'b1);
    send_tick(DRV_UP, 1'b0, 1'b0);
    send_tick(DRV_HOLD, 1'b1, 1'b1);
    send_tick(DRV_DOWN, 1'b0, 1'b0);
    send_tick(DRV_DOWN, 1'b0, 1'b0);
    send_tick(DRV_STOP, 1'b0, 1'b1);
    send_tick(DRV_STOP, 1'b1, 1'b0);
    send_tick(DRV_STOP, 1'b0, 1'b0);
    send_tick(DRV_UP, 1'b0, 1'b0);
    send_tick(DRV_UP, 1'b0, 1'b0);
    repeat (10) send_tick(DRV_STOP, 1'b0, 1'b0);
    send_tick(DRV_HOLD, 1'b0, 1'b1);

    apply_setting(1, 1, 0, 1000);
    run_phase();
    apply_setting(63, 63, 65535, 0);
    run_phase();
    apply_setting(0, 0, 0, 65535);
    run_phase();
    apply_setting(1, 1, 0, 65535);
    run_phase();
    apply_setting(50, 50, 1000, 60000);
    run_phase();
    apply_setting($urandom_range(1, 50), $urandom_range(1, 50),
                  $urandom_range(0, 65535), $urandom_range(0, 65535));
    run_phase();
    apply_setting($urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 65535), $urandom_range(0, 65535));
    run_phase();
    settle();

    $display("Sent %0d ticks under %0d register settings, one long output hold-off.",
             ticks_sent, settings_used);
    $display("Compared %0d result beats, %0d of them at full-on.", checked, full_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("** sine_soft_start_pwm_ramp: PASSED **");
    end else begin
      $display("** sine_soft_start_pwm_ramp: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #1500000;
    $display("Timed out with %0d beats outstanding.", pending);
    $display("** sine_soft_start_pwm_ramp: FAILED **");
    $finish;
  end

endmodule
